@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the header parser checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/swfhp_pkg.sv @@
// ----------------------------------------------------------------------------
// swfhp_pkg
// Types and constants shared by the file header parser and its checker.
// ----------------------------------------------------------------------------
package swfhp_pkg;

	localparam int BYTE_W      = 8;
	localparam int COORD_W     = 31;
	localparam int IDX_W       = 5;
	localparam int RECT_SIZE_W = 5;
	localparam int POS_W       = 8;
	localparam int DATA_W      = 208;
	localparam int STATUS_W    = 2;
	localparam int MIN_TAG_OFFSET = 13;

	localparam logic [7:0] CHAR_F = 8'h46;
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_W = 8'h57;
	localparam logic [7:0] CHAR_S = 8'h53;

	typedef enum logic [1:0] {
		ST_FULL       = 2'd0,
		ST_COMPRESSED = 2'd1,
		ST_BAD_SIG    = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_HEAD = 5'b00010,
		PH_RECT = 5'b00100,
		PH_TAIL = 5'b01000,
		PH_DONE = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [6:0]         pad;
		logic [4:0]         first_tag_offset;
		logic [15:0]        frame_count;
		logic [15:0]        frame_rate;
		logic signed [30:0] y_max;
		logic signed [30:0] y_min;
		logic signed [30:0] x_max;
		logic signed [30:0] x_min;
		logic [31:0]        file_length;
		logic [7:0]         version;
	} hdr_data_t;

	typedef struct packed {
		status_t   status;
		hdr_data_t data;
	} hdr_res_t;

endpackage

@@ rtl/swf_header_parser_unit.sv @@
// ----------------------------------------------------------------------------
// swf_header_parser_unit
// File header parser: signature, version, length, frame rectangle, rate, count.
// ----------------------------------------------------------------------------
// The s_ channel carries the file one byte per word, with s_tuser set on the
// first byte of each file; that byte restarts parsing whatever came before.
// The m_ channel carries one result word per file: m_tuser holds the status
// and m_tdata the header fields. Bytes before any first byte and after the
// result are taken and dropped.
// Every byte is handled in the cycle it is accepted, by the per-byte state
// update that feeds the result register; the rectangle bits of a byte are
// steered into four coordinate lanes at once, so while s_tready is high
// one byte is taken per cycle. A result is built from the byte that ends the
// header, or from the failing signature byte, and is registered.
// The result register is backed by a one-word skid register, so s_tready
// stays high while a result waits; it drops only while both hold a result,
// and rises again the cycle after m_tready is seen high.
// Reset returns the parser to waiting for a first byte and empties both
// output registers.
// ----------------------------------------------------------------------------
module swf_header_parser_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [swfhp_pkg::BYTE_W-1:0]  s_tdata,   // data_byte
	input  logic [0:0]                    s_tuser,   // first_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// version, file_length, x_min, x_max, y_min, y_max, frame_rate,
	// frame_count, first_tag_offset, zero fill
	output logic [swfhp_pkg::DATA_W-1:0]  m_tdata,
	output logic [swfhp_pkg::STATUS_W-1:0] m_tuser   // status
);
	import swfhp_pkg::*;

	phase_t             phase_q, phase_d, phase_eff;
	logic [IDX_W-1:0]   idx_q, idx_d, idx_eff;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [4:0]         n_q, n_d;
	logic [1:0]         tail_q, tail_d;
	logic               is_c_q, is_c_d;
	logic [7:0]         version_q, version_d;
	logic [31:0]        length_q, length_d;
	logic [COORD_W-1:0] coord_q [4];
	logic [COORD_W-1:0] coord_d [4];
	logic [COORD_W-1:0] coord_nxt [4];
	logic [15:0]        rate_q, rate_d;
	logic [7:0]         count_lo_q, count_lo_d;

	logic [4:0] rect_n;
	logic [8:0] rect_end, win_end, win_lo;
	logic [8:0] fld_lo [4];
	logic [8:0] fld_hi [4];
	logic [8:0] ov_lo [4];
	logic [8:0] ov_hi [4];
	logic [3:0] take [4];
	logic [2:0] skip [4];
	logic [7:0] shl [4];
	logic [7:0] fbits [4];
	logic       rect_done;

	logic       in_acc, sig_ok, emit, pop;
	hdr_res_t   res_new, out_q, skid_q;
	logic       out_v_q, skid_v_q;

	function automatic logic [COORD_W-1:0] sext(input logic [COORD_W-1:0] c,
			input logic [4:0] n);
		logic [COORD_W-1:0] low_mask;
		logic [COORD_W-1:0] sign_mask;
		low_mask  = COORD_W'((32'd1 << n) - 32'd1);
		sign_mask = low_mask ^ (low_mask >> 1);
		if (n != 5'd31 && (|(c & sign_mask))) begin
			sext = c | ~low_mask;
		end else begin
			sext = c;
		end
	endfunction

	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = !skid_v_q;
	assign pop      = out_v_q && m_tready;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q.data;
	assign m_tuser  = out_q.status;

	always_comb begin
		rect_n   = (pos_q == '0) ? s_tdata[7:3] : n_q;
		rect_end = 9'(RECT_SIZE_W) + {2'b00, rect_n, 2'b00};
		win_lo   = {1'b0, pos_q};
		win_end  = win_lo + 9'd8;
		rect_done = (win_end >= rect_end);
		for (int k = 0; k < 4; k++) begin
			fld_lo[k] = 9'(RECT_SIZE_W) + 9'(9'(k) * {4'b0000, rect_n});
			fld_hi[k] = fld_lo[k] + {4'b0000, rect_n};
			ov_lo[k]  = (fld_lo[k] > win_lo) ? fld_lo[k] : win_lo;
			ov_hi[k]  = (fld_hi[k] < win_end) ? fld_hi[k] : win_end;
			if (ov_hi[k] > ov_lo[k]) begin
				take[k] = 4'(ov_hi[k] - ov_lo[k]);
				skip[k] = 3'(ov_lo[k] - win_lo);
			end else begin
				take[k] = '0;
				skip[k] = '0;
			end
			shl[k]   = 8'(s_tdata << skip[k]);
			fbits[k] = 8'(shl[k] >> (4'd8 - take[k]));
			if (take[k] == '0) begin
				coord_nxt[k] = coord_q[k];
			end else begin
				coord_nxt[k] = COORD_W'(coord_q[k] << take[k]) | COORD_W'(fbits[k]);
			end
		end
	end

	always_comb begin
		phase_eff = s_tuser[0] ? PH_HEAD : phase_q;
		idx_eff   = s_tuser[0] ? '0 : idx_q;
		phase_d    = phase_q;
		idx_d      = idx_q;
		pos_d      = pos_q;
		n_d        = n_q;
		tail_d     = tail_q;
		is_c_d     = is_c_q;
		version_d  = version_q;
		length_d   = length_q;
		coord_d    = coord_q;
		rate_d     = rate_q;
		count_lo_d = count_lo_q;
		emit       = 1'b0;
		res_new    = '0;
		sig_ok     = 1'b1;
		if (in_acc) begin
			phase_d = phase_eff;
			idx_d   = idx_eff + 1'b1;
			unique case (phase_eff)
				PH_HEAD: begin
					if (idx_eff < 5'd3) begin
						unique case (idx_eff[1:0])
							2'd0: sig_ok = (s_tdata == CHAR_F) || (s_tdata == CHAR_C);
							2'd1: sig_ok = (s_tdata == CHAR_W);
							default: sig_ok = (s_tdata == CHAR_S);
						endcase
						if (idx_eff == '0) begin
							is_c_d = (s_tdata == CHAR_C);
						end
						if (!sig_ok) begin
							emit           = 1'b1;
							res_new.status = ST_BAD_SIG;
							phase_d        = PH_DONE;
						end
					end else if (idx_eff == 5'd3) begin
						version_d = s_tdata;
					end else begin
						length_d[{idx_eff[1:0], 3'b000} +: 8] = s_tdata;
						if (idx_eff == 5'd7) begin
							if (is_c_q) begin
								emit                     = 1'b1;
								res_new.status           = ST_COMPRESSED;
								res_new.data.version     = version_q;
								res_new.data.file_length = length_d;
								phase_d                  = PH_DONE;
							end else begin
								phase_d = PH_RECT;
								pos_d   = '0;
								coord_d = '{default: '0};
							end
						end
					end
				end
				PH_RECT: begin
					coord_d = coord_nxt;
					n_d     = rect_n;
					pos_d   = pos_q + POS_W'(8);
					if (rect_done) begin
						phase_d = PH_TAIL;
						tail_d  = '0;
					end
				end
				PH_TAIL: begin
					tail_d = tail_q + 1'b1;
					unique case (tail_q)
						2'd0: rate_d[7:0]  = s_tdata;
						2'd1: rate_d[15:8] = s_tdata;
						2'd2: count_lo_d   = s_tdata;
						default: begin
							emit                          = 1'b1;
							res_new.status                = ST_FULL;
							res_new.data.version          = version_q;
							res_new.data.file_length      = length_q;
							res_new.data.x_min            = sext(coord_q[0], n_q);
							res_new.data.x_max            = sext(coord_q[1], n_q);
							res_new.data.y_min            = sext(coord_q[2], n_q);
							res_new.data.y_max            = sext(coord_q[3], n_q);
							res_new.data.frame_rate       = rate_q;
							res_new.data.frame_count      = {s_tdata, count_lo_q};
							res_new.data.first_tag_offset = idx_eff + 1'b1;
							phase_d                       = PH_DONE;
						end
					endcase
				end
				default: begin
					idx_d = idx_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			idx_q    <= '0;
			pos_q    <= '0;
			n_q      <= '0;
			tail_q   <= '0;
			is_c_q   <= 1'b0;
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			pos_q   <= pos_d;
			n_q     <= n_d;
			tail_q  <= tail_d;
			is_c_q  <= is_c_d;
			if (!out_v_q || pop) begin
				if (skid_v_q) begin
					out_v_q  <= 1'b1;
					skid_v_q <= emit;
				end else begin
					out_v_q <= emit;
				end
			end else if (emit) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		version_q  <= version_d;
		length_q   <= length_d;
		coord_q    <= coord_d;
		rate_q     <= rate_d;
		count_lo_q <= count_lo_d;
		if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				if (emit) begin
					skid_q <= res_new;
				end
			end else if (emit) begin
				out_q <= res_new;
			end
		end else if (emit) begin
			skid_q <= res_new;
		end
	end

endmodule

@@ rtl/swfhp_checker.sv @@
// ----------------------------------------------------------------------------
// swfhp_checker
// Port-level checks on the header parser, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swfhp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [swfhp_pkg::DATA_W-1:0]   m_tdata,
	input logic [swfhp_pkg::STATUS_W-1:0] m_tuser
);
	import swfhp_pkg::*;

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
	`ASSERT_SAME(a_status_code, clk, arst_n, m_tvalid, m_tuser != 2'd3,
		"undefined status code")
	`ASSERT_SAME(a_bad_sig_zero, clk, arst_n, m_tvalid && (m_tuser == ST_BAD_SIG),
		m_tdata == '0, "bad signature result carries data")
	`ASSERT_SAME(a_comp_zero, clk, arst_n, m_tvalid && (m_tuser == ST_COMPRESSED),
		m_tdata[DATA_W-1:40] == '0, "compressed result carries rectangle data")
	`ASSERT_SAME(a_tag_offset, clk, arst_n, m_tvalid && (m_tuser == ST_FULL),
		m_tdata[200:196] >= 5'(MIN_TAG_OFFSET), "header shorter than possible")

endmodule

bind swf_header_parser_unit swfhp_checker u_swfhp_checker (.*);

@@ test/swf_header_parser_unit_test.sv @@
// ----------------------------------------------------------------------------
// swf_header_parser_unit_test
// Self-checking bench for the file header parser. Files are sent one byte per
// word: well-formed headers with random rectangle sizes and contents,
// compressed files, bad signatures, files cut short by a new first byte, and
// bytes the parser must drop. A behavioral parser predicts each result word
// and a monitor compares every field against it, under several idle and stall
// mixes on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module swf_header_parser_unit_test;
	import swfhp_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [BYTE_W-1:0]    s_tdata = '0;
	logic [0:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [DATA_W-1:0]    m_tdata;
	logic [STATUS_W-1:0]  m_tuser;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int bytes_parsed = 0;
	int mismatches = 0;
	int cycle_count = 0;

	hdr_res_t         pending_headers[$];
	logic [7:0]       file_bytes[$];

	// Behavioral parser state.
	phase_t           hp_phase;
	logic [4:0]       hp_pos;
	logic [23:0]      hp_sig;
	logic [7:0]       hp_ver;
	logic [31:0]      hp_len;
	logic [4:0]       hp_size_acc;
	logic [4:0]       hp_bit_cnt;
	logic [4:0]       hp_nbits;
	logic [2:0]       hp_field;
	logic [30:0]      hp_coord[4];
	logic [15:0]      hp_rate;
	logic [15:0]      hp_count;

	swf_header_parser_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic clear_parser();
		hp_phase = PH_IDLE;
		hp_pos = '0;
		hp_sig = '0;
		hp_ver = '0;
		hp_len = '0;
		hp_size_acc = '0;
		hp_bit_cnt = '0;
		hp_nbits = '0;
		hp_field = '0;
		hp_coord = '{default: '0};
		hp_rate = '0;
		hp_count = '0;
	endtask

	task automatic take_rect_bit(input logic rb);
		logic [30:0] c;
		int k;
		if (hp_field == 0) begin
			hp_size_acc = {hp_size_acc[3:0], rb};
			hp_bit_cnt++;
			if (hp_bit_cnt == 5) begin
				hp_nbits = hp_size_acc;
				hp_bit_cnt = '0;
				hp_field = (hp_nbits != 0) ? 3'd1 : 3'd5;
			end
		end else if (hp_field <= 4) begin
			k = hp_field - 1;
			c = {hp_coord[k][29:0], rb};
			hp_bit_cnt++;
			if (hp_bit_cnt >= hp_nbits) begin
				if (hp_nbits >= 1 && hp_nbits < 31 && c[hp_nbits - 1])
					c = c | ~((31'd1 << hp_nbits) - 31'd1);
				hp_field++;
				hp_bit_cnt = '0;
			end
			hp_coord[k] = c;
		end
	endtask

	// Advances the parser by one byte; used is low when the byte is dropped.
	task automatic predict_byte(input logic [7:0] b, input logic first, output bit used);
		hdr_res_t r;
		bit sig_ok;
		int i;
		r = '0;
		used = 1'b0;
		if (first) begin
			clear_parser();
			hp_phase = PH_HEAD;
		end
		case (hp_phase)
			PH_HEAD: begin
				used = 1'b1;
				if (hp_pos < 3) begin
					hp_sig[8 * hp_pos +: 8] = b;
					if (hp_pos == 0)
						sig_ok = (b == CHAR_F) || (b == CHAR_C);
					else if (hp_pos == 1)
						sig_ok = (b == CHAR_W);
					else
						sig_ok = (b == CHAR_S);
					if (!sig_ok) begin
						r.status = ST_BAD_SIG;
						pending_headers.push_back(r);
						hp_phase = PH_DONE;
						return;
					end
				end else if (hp_pos == 3) begin
					hp_ver = b;
				end else begin
					hp_len[8 * ((hp_pos - 4) & 3) +: 8] = b;
					if (hp_pos >= 7) begin
						if (hp_sig[7:0] == CHAR_C) begin
							r.status = ST_COMPRESSED;
							r.data.version = hp_ver;
							r.data.file_length = hp_len;
							pending_headers.push_back(r);
							hp_phase = PH_DONE;
							return;
						end
						hp_phase = PH_RECT;
					end
				end
			end
			PH_RECT: begin
				used = 1'b1;
				for (i = 7; i >= 0; i--) begin
					take_rect_bit(b[i]);
					if (hp_field >= 5)
						break;
				end
				if (hp_field >= 5) begin
					hp_phase = PH_TAIL;
					hp_bit_cnt = '0;
				end
			end
			PH_TAIL: begin
				used = 1'b1;
				case (hp_bit_cnt)
					5'd0: hp_rate = {8'h00, b};
					5'd1: hp_rate[15:8] = b;
					5'd2: hp_count = {8'h00, b};
					default: begin
						hp_count[15:8] = b;
						r.status = ST_FULL;
						r.data.version = hp_ver;
						r.data.file_length = hp_len;
						r.data.x_min = hp_coord[0];
						r.data.x_max = hp_coord[1];
						r.data.y_min = hp_coord[2];
						r.data.y_max = hp_coord[3];
						r.data.frame_rate = hp_rate;
						r.data.frame_count = hp_count;
						r.data.first_tag_offset = hp_pos + 5'd1;
						pending_headers.push_back(r);
						hp_phase = PH_DONE;
						return;
					end
				endcase
				hp_bit_cnt++;
			end
			default: return;
		endcase
		hp_pos = hp_pos + 5'd1;
	endtask

	task automatic compare_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] %s mismatch: expected %h, got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		hdr_res_t got;
		hdr_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = hdr_res_t'({m_tuser, m_tdata});
			if (pending_headers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected result word, status %0d", $time, m_tuser);
			end else begin
				want = pending_headers.pop_front();
				compare_field("status", want.status, got.status);
				compare_field("version", want.data.version, got.data.version);
				compare_field("file_length", want.data.file_length, got.data.file_length);
				compare_field("x_min", want.data.x_min, got.data.x_min);
				compare_field("x_max", want.data.x_max, got.data.x_max);
				compare_field("y_min", want.data.y_min, got.data.y_min);
				compare_field("y_max", want.data.y_max, got.data.y_max);
				compare_field("frame_rate", want.data.frame_rate, got.data.frame_rate);
				compare_field("frame_count", want.data.frame_count, got.data.frame_count);
				compare_field("first_tag_offset", want.data.first_tag_offset,
					got.data.first_tag_offset);
				compare_field("zero fill", want.data.pad, got.data.pad);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic first);
		bit used;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= first;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_byte(b, first, used);
		if (used)
			bytes_parsed++;
	endtask

	task automatic send_file(input int keep);
		int i;
		for (i = 0; i < keep && i < file_bytes.size(); i++)
			send_byte(file_bytes[i], i == 0);
	endtask

	task automatic send_junk(input int n);
		repeat (n)
			send_byte(8'($urandom_range(255)), 1'b0);
	endtask

	task automatic build_full_header(input logic [4:0] nb, input logic [30:0] xa,
			input logic [30:0] xb, input logic [30:0] ya, input logic [30:0] yb,
			input logic [7:0] ver, input logic [31:0] len, input logic [15:0] rate,
			input logic [15:0] count);
		bit bits[$];
		logic [30:0] cv[4];
		logic [7:0] acc;
		int i, j, k;
		cv = '{xa, xb, ya, yb};
		file_bytes = {CHAR_F, CHAR_W, CHAR_S, ver, len[7:0], len[15:8], len[23:16], len[31:24]};
		for (i = 4; i >= 0; i--)
			bits.push_back(nb[i]);
		for (k = 0; k < 4; k++)
			for (i = int'(nb) - 1; i >= 0; i--)
				bits.push_back(cv[k][i]);
		while (bits.size() % 8 != 0)
			bits.push_back($urandom_range(1));
		for (i = 0; i < bits.size(); i += 8) begin
			acc = '0;
			for (j = 0; j < 8; j++)
				acc = {acc[6:0], bits[i + j]};
			file_bytes.push_back(acc);
		end
		file_bytes.push_back(rate[7:0]);
		file_bytes.push_back(rate[15:8]);
		file_bytes.push_back(count[7:0]);
		file_bytes.push_back(count[15:8]);
	endtask

	task automatic build_compressed(input logic [7:0] ver, input logic [31:0] len);
		file_bytes = {CHAR_C, CHAR_W, CHAR_S, ver, len[7:0], len[15:8], len[23:16], len[31:24]};
	endtask

	task automatic build_bad_signature(input int pos);
		logic [7:0] b;
		file_bytes = {($urandom_range(1) ? CHAR_F : CHAR_C), CHAR_W, CHAR_S};
		do
			b = 8'($urandom_range(255));
		while ((pos == 0 && (b == CHAR_F || b == CHAR_C)) ||
			(pos == 1 && b == CHAR_W) || (pos == 2 && b == CHAR_S));
		file_bytes[pos] = b;
		while (file_bytes.size() > pos + 1)
			void'(file_bytes.pop_back());
	endtask

	task automatic build_random_full();
		logic [4:0] nb;
		case ($urandom_range(9))
			0: nb = 5'd0;
			1: nb = 5'd1;
			2: nb = 5'd31;
			default: nb = 5'($urandom_range(31));
		endcase
		build_full_header(nb, 31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom),
			8'($urandom), $urandom, 16'($urandom), 16'($urandom));
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (pending_headers.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_ignored_before_first();
		send_junk(4);
	endtask

	task automatic test_signature_checks();
		build_bad_signature(0);
		send_file(file_bytes.size());
		send_junk(2);
		build_bad_signature(1);
		send_file(file_bytes.size());
		build_bad_signature(2);
		send_file(file_bytes.size());
		build_compressed(8'hFF, 32'hFFFF_FFFF);
		send_file(file_bytes.size());
		send_junk(1);
		build_compressed(8'h00, 32'h0000_0000);
		send_file(file_bytes.size());
	endtask

	task automatic test_rectangle_sizes();
		build_full_header(5'd0, '0, '0, '0, '0, 8'h00, 32'h0, 16'h0000, 16'h0000);
		send_file(file_bytes.size());
		build_full_header(5'd1, 31'd0, 31'd1, 31'd1, 31'd0, 8'hFF, 32'hFFFF_FFFF,
			16'hFFFF, 16'hFFFF);
		send_file(file_bytes.size());
		build_full_header(5'd31, 31'h4000_0000, 31'h3FFF_FFFF, 31'h7FFF_FFFF, 31'h0,
			8'h0A, 32'h1234_5678, 16'h1800, 16'h0001);
		send_file(file_bytes.size());
		build_full_header(5'd30, 31'h2000_0000, 31'h1FFF_FFFF, 31'h3FFF_FFFF, 31'h1,
			8'h55, 32'hA5A5_5A5A, 16'h00FF, 16'hFF00);
		send_file(file_bytes.size());
		send_junk(3);
	endtask

	task automatic test_restart_mid_file();
		build_full_header(5'd12, 31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom),
			8'h08, 32'd4096, 16'h0C00, 16'd100);
		send_file(11);
		build_compressed(8'h06, 32'd777);
		send_file(5);
		build_random_full();
		send_file(file_bytes.size() - 1);
		build_random_full();
		send_file(file_bytes.size());
	endtask

	task automatic test_pause_for_drain();
		recv_stall_pct = 61;
		build_random_full();
		send_file(file_bytes.size());
		wait_for_results();
		recv_stall_pct = 0;
		build_random_full();
		send_file(file_bytes.size());
	endtask

	task automatic test_random_headers(input int target, input int idle_pct, input int stall_pct);
		int stop_at;
		int pick;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		stop_at = bytes_parsed + target;
		while (bytes_parsed < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 62) begin
				build_random_full();
				send_file(file_bytes.size());
				if ($urandom_range(4) == 0)
					send_junk($urandom_range(1, 3));
			end else if (pick < 72) begin
				build_compressed(8'($urandom), $urandom);
				send_file(file_bytes.size());
			end else if (pick < 80) begin
				build_bad_signature($urandom_range(2));
				send_file(file_bytes.size());
			end else if (pick < 94) begin
				if ($urandom_range(3) == 0)
					build_compressed(8'($urandom), $urandom);
				else
					build_random_full();
				send_file($urandom_range(1, file_bytes.size() - 1));
			end else begin
				send_junk($urandom_range(1, 4));
			end
		end
	endtask

	initial begin
		clear_parser();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ignored_before_first();
		test_signature_checks();
		test_rectangle_sizes();
		test_restart_mid_file();
		test_pause_for_drain();
		test_random_headers(300, 0, 0);
		test_random_headers(290, 61, 0);
		test_random_headers(290, 0, 61);
		test_random_headers(290, 7, 7);
		test_random_headers(280, 0, 0);
		wait_for_results();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
